>>> design/rpfa_pkg.sv
// ============================================================================
// rpfa_pkg: shared definitions of the random page frame allocator
// Sizes, field widths, operation and status codes, controller states and the
// control bundle that drives the free list cell chain.
// ============================================================================
package rpfa_pkg;

  localparam int FREE_DEPTH = 1024;
  localparam int LOG_DEPTH  = 512;
  localparam int PAGE_BITS  = 12;

  localparam int ADDR_W     = 32;
  localparam int FRAME_W    = ADDR_W - PAGE_BITS;
  localparam int FREE_IDX_W = $clog2(FREE_DEPTH);
  localparam int FREE_CNT_W = $clog2(FREE_DEPTH + 1);
  localparam int LOG_IDX_W  = $clog2(LOG_DEPTH);
  localparam int LOG_CNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int RND_W      = 31;
  localparam int DUMP_W     = 7;
  localparam int MAX_DUMP   = 64;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;

  localparam int LOW_W      = 20;
  localparam int TOP_W      = 21;
  localparam int CMP_W      = (FRAME_W > TOP_W) ? FRAME_W : TOP_W;
  localparam logic [TOP_W-1:0] TOP_RESET = TOP_W'(57344);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TOP_W;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_FRAME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_FRAME = 1'b1;

  localparam int IN_DATA_W  = ((ADDR_W + RND_W + DUMP_W + 7) / 8) * 8;
  localparam int DIV_W      = FREE_IDX_W + 1;
  localparam int DIV_CNT_W  = $clog2(RND_W + 1);

  localparam logic [OP_W-1:0] OP_FREE  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_DUMP = 3'd4;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_DIV,
    FSM_CHAIN,
    FSM_LOG_RD,
    FSM_EMIT
  } fsm_state_e;

  typedef struct packed {
    logic                  push;
    logic                  pull;
    logic                  rd_load;
    logic                  rd_shift;
    logic [FREE_IDX_W-1:0] pos;
    logic [FRAME_W-1:0]    frame;
  } cell_ctl_t;

endpackage

>>> design/rpfa_ram.sv
// ============================================================================
// rpfa_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module rpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/rpfa_cell.sv
// ============================================================================
// rpfa_cell: one entry of the free list chain
// Holds one frame number. It takes its head-side neighbor on a push, its
// tail-side neighbor when an entry at or ahead of it is removed, and passes
// the removed frame toward the head on a separate read chain.
// ============================================================================
module rpfa_cell (
  input  logic                                clk_i,
  input  rpfa_pkg::cell_ctl_t                 ctl_i,
  input  logic [rpfa_pkg::FREE_IDX_W-1:0]     idx_i,
  input  logic [rpfa_pkg::FRAME_W-1:0]        prev_i,
  input  logic [rpfa_pkg::FRAME_W-1:0]        next_i,
  input  logic [rpfa_pkg::FRAME_W-1:0]        rd_next_i,
  output logic [rpfa_pkg::FRAME_W-1:0]        entry_o,
  output logic [rpfa_pkg::FRAME_W-1:0]        rd_o
);

  logic [rpfa_pkg::FRAME_W-1:0] entry_q, entry_d;
  logic [rpfa_pkg::FRAME_W-1:0] rd_q, rd_d;

  always_comb begin
    priority if (ctl_i.push) begin
      entry_d = prev_i;
    end else if (ctl_i.pull && (idx_i >= ctl_i.pos)) begin
      entry_d = next_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_comb begin
    priority if (ctl_i.rd_load && (idx_i == ctl_i.pos)) begin
      rd_d = entry_q;
    end else if (ctl_i.rd_shift) begin
      rd_d = rd_next_i;
    end else begin
      rd_d = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    rd_q    <= rd_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = rd_q;

endmodule

>>> design/rpfa_mod.sv
// ============================================================================
// rpfa_mod: serial modulo unit
// Restoring division of the random value by the free count, one quotient bit
// per cycle; only the remainder is kept.
// ============================================================================
module rpfa_mod (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rpfa_pkg::RND_W-1:0]      dividend_i,
  input  logic [rpfa_pkg::FREE_CNT_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [rpfa_pkg::FREE_IDX_W-1:0] rem_o
);

  logic [rpfa_pkg::RND_W-1:0]     dvd_q, dvd_d;
  logic [rpfa_pkg::DIV_W-1:0]     rem_q, rem_d;
  logic [rpfa_pkg::DIV_W-1:0]     dsr_q, dsr_d;
  logic [rpfa_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [rpfa_pkg::DIV_W-1:0]     trial;

  assign trial = {rem_q[rpfa_pkg::DIV_W-2:0], dvd_q[rpfa_pkg::RND_W-1]};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = rpfa_pkg::DIV_W'(divisor_i);
      cnt_d  = rpfa_pkg::DIV_CNT_W'(rpfa_pkg::RND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = (trial >= dsr_q) ? (trial - dsr_q) : trial;
      dvd_d = {dvd_q[rpfa_pkg::RND_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == rpfa_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[rpfa_pkg::FREE_IDX_W-1:0];

endmodule

>>> design/random_page_frame_allocator.sv
// ============================================================================
// random_page_frame_allocator: randomized free list page frame allocator
// Keeps an ordered list of free frames in a chain of cells and a ring log of
// handed-out frames in a RAM.
// ============================================================================
// Usage: each request on the slave stream carries an operation in tuser
// (free, allocate, dump) and address, random value and dump count in tdata.
// Every request gives one result transfer on the master stream, a dump gives
// one per reported entry, with status in tuser and tlast on the final one.
// The user writes the frame window registers on the configuration channel only
// while the block is idle; the block does no such check and is always ready.
// Requests are handled one at a time. A free, a rejected request or an
// unused code is settled in the execute state, which then loads its result
// into the output register. An allocate first finds the position p, counted
// from the list head, as the remainder from the serial modulo unit; the
// frame then travels along the read chain of the cells to the head. A dump
// reads each entry, newest first, through the registered read of the log RAM.
// After reset the list and the log are empty, the lower frame bound is zero
// and the upper bound is 57344. A result waits in the output register while
// the receiver stalls; one more request is taken meanwhile and then held.
// ============================================================================
module random_page_frame_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Fields from bit 0: address, random_value, dump_count, zero padding.
  input  logic [rpfa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // Fields from bit 0: operation.
  input  logic [rpfa_pkg::OP_W-1:0]        s_axis_tuser,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: page_address.
  output logic [rpfa_pkg::ADDR_W-1:0]      m_axis_tdata,
  // Fields from bit 0: status.
  output logic [rpfa_pkg::STATUS_W-1:0]    m_axis_tuser,
  output logic                             m_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rpfa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rpfa_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  rpfa_pkg::fsm_state_e state_q, state_d;

  logic [rpfa_pkg::OP_W-1:0]       op_q;
  logic [rpfa_pkg::ADDR_W-1:0]     addr_q;
  logic [rpfa_pkg::RND_W-1:0]      rnd_q;
  logic [rpfa_pkg::DUMP_W-1:0]     dump_q;
  logic [rpfa_pkg::FREE_CNT_W-1:0] free_cnt_q;
  logic [rpfa_pkg::FREE_IDX_W-1:0] wait_q;
  logic [rpfa_pkg::LOG_IDX_W-1:0]  wp_q;
  logic [rpfa_pkg::LOG_CNT_W-1:0]  log_cnt_q;
  logic [rpfa_pkg::LOG_IDX_W-1:0]  rd_idx_q;
  logic [rpfa_pkg::DUMP_W-1:0]     remain_q;
  logic [rpfa_pkg::LOW_W-1:0]      low_frame_q;
  logic [rpfa_pkg::TOP_W-1:0]      top_frame_q;

  logic                            out_valid_q;
  logic [rpfa_pkg::ADDR_W-1:0]     out_page_q;
  logic [rpfa_pkg::STATUS_W-1:0]   out_status_q;
  logic                            out_last_q;

  logic                            accept;
  logic                            out_free;
  logic                            out_load;
  logic [rpfa_pkg::ADDR_W-1:0]     out_page;
  logic [rpfa_pkg::STATUS_W-1:0]   out_status;
  logic                            out_last;
  logic                            div_start;
  logic                            take;
  logic                            log_wr;
  logic                            log_re;
  logic                            dump_start;
  logic                            dump_next;
  rpfa_pkg::cell_ctl_t             ctl;

  logic                            div_done;
  logic [rpfa_pkg::FREE_IDX_W-1:0] div_rem;
  logic [rpfa_pkg::FRAME_W-1:0]    log_rdata;
  logic [rpfa_pkg::FRAME_W-1:0]    free_frame;
  logic                            addr_bad;
  logic                            list_full;
  logic                            list_empty;
  logic                            dump_bad;

  logic [rpfa_pkg::FRAME_W-1:0] entry_w   [rpfa_pkg::FREE_DEPTH];
  logic [rpfa_pkg::FRAME_W-1:0] rd_w      [rpfa_pkg::FREE_DEPTH];
  logic [rpfa_pkg::FRAME_W-1:0] prev_w    [rpfa_pkg::FREE_DEPTH];
  logic [rpfa_pkg::FRAME_W-1:0] next_w    [rpfa_pkg::FREE_DEPTH];
  logic [rpfa_pkg::FRAME_W-1:0] rd_next_w [rpfa_pkg::FREE_DEPTH];

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == rpfa_pkg::FSM_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign free_frame = addr_q[rpfa_pkg::ADDR_W-1:rpfa_pkg::PAGE_BITS];
  assign addr_bad   = (addr_q[rpfa_pkg::PAGE_BITS-1:0] != '0)
                   || (rpfa_pkg::CMP_W'(free_frame) < rpfa_pkg::CMP_W'(low_frame_q))
                   || (rpfa_pkg::CMP_W'(free_frame) >= rpfa_pkg::CMP_W'(top_frame_q));
  assign list_full  = (free_cnt_q == rpfa_pkg::FREE_CNT_W'(rpfa_pkg::FREE_DEPTH));
  assign list_empty = (free_cnt_q == '0);
  assign dump_bad   = (dump_q == '0)
                   || (rpfa_pkg::LOG_CNT_W'(dump_q) > log_cnt_q)
                   || (dump_q > rpfa_pkg::DUMP_W'(rpfa_pkg::MAX_DUMP));

  // Free list cell chain, cell 0 is the list head.
  for (genvar k = 0; k < rpfa_pkg::FREE_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign prev_w[k] = ctl.frame;
    end else begin : g_body
      assign prev_w[k] = entry_w[k-1];
    end
    if (k == rpfa_pkg::FREE_DEPTH - 1) begin : g_tail
      assign next_w[k]    = '0;
      assign rd_next_w[k] = '0;
    end else begin : g_inner
      assign next_w[k]    = entry_w[k+1];
      assign rd_next_w[k] = rd_w[k+1];
    end
    rpfa_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .idx_i     (rpfa_pkg::FREE_IDX_W'(k)),
      .prev_i    (prev_w[k]),
      .next_i    (next_w[k]),
      .rd_next_i (rd_next_w[k]),
      .entry_o   (entry_w[k]),
      .rd_o      (rd_w[k])
    );
  end

  rpfa_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rnd_q),
    .divisor_i  (free_cnt_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  rpfa_ram #(
    .WIDTH (rpfa_pkg::FRAME_W),
    .DEPTH (rpfa_pkg::LOG_DEPTH)
  ) u_log (
    .clk_i   (clk_i),
    .we_i    (log_wr),
    .waddr_i (wp_q),
    .wdata_i (rd_w[0]),
    .re_i    (log_re),
    .raddr_i (rd_idx_q),
    .rdata_o (log_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpfa_pkg::FSM_IDLE: begin
        if (accept) begin
          state_d = rpfa_pkg::FSM_EXEC;
        end
      end
      rpfa_pkg::FSM_EXEC: begin
        unique case (op_q)
          rpfa_pkg::OP_ALLOC: begin
            if (!list_empty) begin
              state_d = rpfa_pkg::FSM_DIV;
            end else if (out_free) begin
              state_d = rpfa_pkg::FSM_IDLE;
            end
          end
          rpfa_pkg::OP_DUMP: begin
            if (!dump_bad) begin
              state_d = rpfa_pkg::FSM_LOG_RD;
            end else if (out_free) begin
              state_d = rpfa_pkg::FSM_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              state_d = rpfa_pkg::FSM_IDLE;
            end
          end
        endcase
      end
      rpfa_pkg::FSM_DIV: begin
        if (div_done) begin
          state_d = rpfa_pkg::FSM_CHAIN;
        end
      end
      rpfa_pkg::FSM_CHAIN: begin
        if ((wait_q == '0) && out_free) begin
          state_d = rpfa_pkg::FSM_IDLE;
        end
      end
      rpfa_pkg::FSM_LOG_RD: begin
        state_d = rpfa_pkg::FSM_EMIT;
      end
      rpfa_pkg::FSM_EMIT: begin
        if (out_free) begin
          state_d = (remain_q == rpfa_pkg::DUMP_W'(1)) ? rpfa_pkg::FSM_IDLE
                                                       : rpfa_pkg::FSM_LOG_RD;
        end
      end
      default: begin
        state_d = rpfa_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    out_load     = 1'b0;
    out_page     = '0;
    out_status   = rpfa_pkg::ST_OK;
    out_last     = 1'b1;
    div_start    = 1'b0;
    take         = 1'b0;
    log_wr       = 1'b0;
    log_re       = 1'b0;
    dump_start   = 1'b0;
    dump_next    = 1'b0;
    ctl.push     = 1'b0;
    ctl.pull     = 1'b0;
    ctl.rd_load  = 1'b0;
    ctl.rd_shift = 1'b0;
    ctl.pos      = div_rem;
    ctl.frame    = free_frame;
    unique case (state_q)
      rpfa_pkg::FSM_IDLE: begin
      end
      rpfa_pkg::FSM_EXEC: begin
        unique case (op_q)
          rpfa_pkg::OP_FREE: begin
            if (out_free) begin
              out_load = 1'b1;
              priority if (addr_bad) begin
                out_status = rpfa_pkg::ST_BAD_ADDR;
              end else if (list_full) begin
                out_status = rpfa_pkg::ST_FULL;
              end else begin
                ctl.push = 1'b1;
              end
            end
          end
          rpfa_pkg::OP_ALLOC: begin
            if (!list_empty) begin
              div_start = 1'b1;
            end else if (out_free) begin
              out_load   = 1'b1;
              out_status = rpfa_pkg::ST_EMPTY;
            end
          end
          rpfa_pkg::OP_DUMP: begin
            if (!dump_bad) begin
              dump_start = 1'b1;
            end else if (out_free) begin
              out_load   = 1'b1;
              out_status = rpfa_pkg::ST_BAD_DUMP;
            end
          end
          default: begin
            out_load = out_free;
          end
        endcase
      end
      rpfa_pkg::FSM_DIV: begin
        if (div_done) begin
          take        = 1'b1;
          ctl.pull    = 1'b1;
          ctl.rd_load = 1'b1;
        end
      end
      rpfa_pkg::FSM_CHAIN: begin
        if (wait_q != '0) begin
          ctl.rd_shift = 1'b1;
        end else if (out_free) begin
          out_load = 1'b1;
          out_page = {rd_w[0], {rpfa_pkg::PAGE_BITS{1'b0}}};
          log_wr   = 1'b1;
        end
      end
      rpfa_pkg::FSM_LOG_RD: begin
        log_re = 1'b1;
      end
      rpfa_pkg::FSM_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_page  = {log_rdata, {rpfa_pkg::PAGE_BITS{1'b0}}};
          out_last  = (remain_q == rpfa_pkg::DUMP_W'(1));
          dump_next = !out_last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpfa_pkg::FSM_IDLE;
      free_cnt_q  <= '0;
      wp_q        <= '0;
      log_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      low_frame_q <= '0;
      top_frame_q <= rpfa_pkg::TOP_RESET;
    end else begin
      state_q <= state_d;
      if (ctl.push) begin
        free_cnt_q <= free_cnt_q + 1'b1;
      end else if (ctl.pull) begin
        free_cnt_q <= free_cnt_q - 1'b1;
      end
      if (log_wr) begin
        wp_q <= (wp_q == rpfa_pkg::LOG_IDX_W'(rpfa_pkg::LOG_DEPTH - 1)) ? '0 : wp_q + 1'b1;
        if (log_cnt_q != rpfa_pkg::LOG_CNT_W'(rpfa_pkg::LOG_DEPTH)) begin
          log_cnt_q <= log_cnt_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          rpfa_pkg::CFG_LOW_FRAME: low_frame_q <= cfg_data_i[rpfa_pkg::LOW_W-1:0];
          rpfa_pkg::CFG_TOP_FRAME: top_frame_q <= cfg_data_i[rpfa_pkg::TOP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser;
      addr_q <= s_axis_tdata[rpfa_pkg::ADDR_W-1:0];
      rnd_q  <= s_axis_tdata[rpfa_pkg::ADDR_W+rpfa_pkg::RND_W-1:rpfa_pkg::ADDR_W];
      dump_q <= s_axis_tdata[rpfa_pkg::ADDR_W+rpfa_pkg::RND_W+rpfa_pkg::DUMP_W-1:
                             rpfa_pkg::ADDR_W+rpfa_pkg::RND_W];
    end
    if (take) begin
      wait_q <= div_rem;
    end else if (ctl.rd_shift) begin
      wait_q <= wait_q - 1'b1;
    end
    if (dump_start) begin
      rd_idx_q <= (wp_q == '0) ? rpfa_pkg::LOG_IDX_W'(rpfa_pkg::LOG_DEPTH - 1) : wp_q - 1'b1;
      remain_q <= dump_q;
    end else if (dump_next) begin
      rd_idx_q <= (rd_idx_q == '0) ? rpfa_pkg::LOG_IDX_W'(rpfa_pkg::LOG_DEPTH - 1)
                                   : rd_idx_q - 1'b1;
      remain_q <= remain_q - 1'b1;
    end
    if (out_load) begin
      out_page_q   <= out_page;
      out_status_q <= out_status;
      out_last_q   <= out_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_page_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  a_pull_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.pull |=> (free_cnt_q == $past(free_cnt_q) - 1'b1))
    else $error("Free count did not drop by one after a removal.");

  a_pos_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.pull |-> (rpfa_pkg::FREE_CNT_W'(ctl.pos) < free_cnt_q))
    else $error("Removal position lies beyond the free list.");

  a_log_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (log_cnt_q >= $past(log_cnt_q)))
    else $error("Log count decreased.");

  a_no_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q != rpfa_pkg::FSM_IDLE))
    else $error("Result loaded with no request in progress.");

endmodule

>>> tb/sv/random_page_frame_allocator_tb.sv
// ============================================================================
// random_page_frame_allocator_tb: self-checking bench for the page allocator
// Frees, allocates, dumps and unused codes go in on the request stream. A
// predictor holds its own free list, allocation log and frame window, and
// works out the result transfers of every accepted request. The results are
// checked field by field in order. Directed requests cover rejected
// addresses, an empty list, an empty log, the frame window edges and dump
// counts out of range. Randomized requests then run under two random frame
// windows, with bursty requests and a stalling receiver.
// ============================================================================
module random_page_frame_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rpfa_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [rpfa_pkg::OP_W-1:0]   op;
    logic [rpfa_pkg::ADDR_W-1:0] addr;
    logic [rpfa_pkg::RND_W-1:0]  rnd;
    logic [rpfa_pkg::DUMP_W-1:0] count;
  } request_t;

  typedef struct packed {
    logic [rpfa_pkg::STATUS_W-1:0] status;
    logic [rpfa_pkg::ADDR_W-1:0]   page;
    logic                          last;
  } response_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_LIGHT} rx_pattern_e;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic [rpfa_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [rpfa_pkg::OP_W-1:0]       s_axis_tuser  = rpfa_pkg::OP_FREE;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [rpfa_pkg::ADDR_W-1:0]     m_axis_tdata;
  logic [rpfa_pkg::STATUS_W-1:0]   m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [rpfa_pkg::CFG_IDX_W-1:0]  cfg_index_i   = rpfa_pkg::CFG_LOW_FRAME;
  logic [rpfa_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  random_page_frame_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  request_t    queued_requests[$];
  response_t   awaited_responses[$];
  int unsigned error_count = 0;

  logic [rpfa_pkg::FRAME_W-1:0] free_frames[$];
  logic [rpfa_pkg::FRAME_W-1:0] handed_out[rpfa_pkg::LOG_DEPTH];
  int unsigned                  handed_wp    = 0;
  int unsigned                  handed_count = 0;
  logic [rpfa_pkg::LOW_W-1:0]   frame_low    = '0;
  logic [rpfa_pkg::TOP_W-1:0]   frame_top    = rpfa_pkg::TOP_RESET;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void compute_responses(request_t req);
    logic [rpfa_pkg::FRAME_W-1:0] frame;
    int unsigned                  pos;
    int unsigned                  slot;
    int unsigned                  idx;
    response_t                    rsp;
    rsp = '{status: rpfa_pkg::ST_OK, page: '0, last: 1'b1};
    case (req.op)
      rpfa_pkg::OP_FREE: begin
        frame = req.addr[rpfa_pkg::ADDR_W-1:rpfa_pkg::PAGE_BITS];
        if (req.addr[rpfa_pkg::PAGE_BITS-1:0] != '0 || frame < frame_low
            || frame >= frame_top) begin
          rsp.status = rpfa_pkg::ST_BAD_ADDR;
        end else if (free_frames.size() >= rpfa_pkg::FREE_DEPTH) begin
          rsp.status = rpfa_pkg::ST_FULL;
        end else begin
          free_frames.push_back(frame);
        end
        awaited_responses.push_back(rsp);
      end
      rpfa_pkg::OP_ALLOC: begin
        if (free_frames.size() == 0) begin
          rsp.status = rpfa_pkg::ST_EMPTY;
        end else begin
          // The head of the list is the back of the queue.
          pos  = req.rnd % free_frames.size();
          slot = free_frames.size() - 1 - pos;
          frame = free_frames[slot];
          free_frames.delete(slot);
          handed_out[handed_wp] = frame;
          handed_wp = (handed_wp + 1) % rpfa_pkg::LOG_DEPTH;
          if (handed_count < rpfa_pkg::LOG_DEPTH) handed_count++;
          rsp.page = {frame, {rpfa_pkg::PAGE_BITS{1'b0}}};
        end
        awaited_responses.push_back(rsp);
      end
      rpfa_pkg::OP_DUMP: begin
        if (req.count == 0 || req.count > handed_count || req.count > rpfa_pkg::MAX_DUMP) begin
          rsp.status = rpfa_pkg::ST_BAD_DUMP;
          awaited_responses.push_back(rsp);
        end else begin
          idx = handed_wp;
          for (int i = 0; i < req.count; i++) begin
            idx = (idx + rpfa_pkg::LOG_DEPTH - 1) % rpfa_pkg::LOG_DEPTH;
            rsp.page = {handed_out[idx], {rpfa_pkg::PAGE_BITS{1'b0}}};
            rsp.last = (i == req.count - 1);
            awaited_responses.push_back(rsp);
          end
        end
      end
      default: begin
        awaited_responses.push_back(rsp);
      end
    endcase
  endfunction

  function automatic void enqueue(logic [rpfa_pkg::OP_W-1:0] op,
                                  logic [rpfa_pkg::ADDR_W-1:0] addr,
                                  int unsigned rnd, int unsigned count);
    queued_requests.push_back('{op: op, addr: addr, rnd: rpfa_pkg::RND_W'(rnd),
                                count: rpfa_pkg::DUMP_W'(count)});
  endfunction

  task automatic write_register(logic [rpfa_pkg::CFG_IDX_W-1:0] index, int unsigned value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= rpfa_pkg::CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == rpfa_pkg::CFG_LOW_FRAME) begin
      frame_low = rpfa_pkg::LOW_W'(value);
    end else begin
      frame_top = rpfa_pkg::TOP_W'(value);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (queued_requests.size() != 0 || s_axis_tvalid || awaited_responses.size() != 0);
  endtask

  // Request driver: bursts of random length separated by random gaps.
  request_t    accepted_req;
  request_t    upcoming_req;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        accepted_req = '{op:    s_axis_tuser,
                         addr:  s_axis_tdata[rpfa_pkg::ADDR_W-1:0],
                         rnd:   s_axis_tdata[rpfa_pkg::ADDR_W+rpfa_pkg::RND_W-1:
                                             rpfa_pkg::ADDR_W],
                         count: s_axis_tdata[rpfa_pkg::ADDR_W+rpfa_pkg::RND_W+rpfa_pkg::DUMP_W-1:
                                             rpfa_pkg::ADDR_W+rpfa_pkg::RND_W]};
        compute_responses(accepted_req);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          upcoming_req = queued_requests.pop_front();
          s_axis_tuser  <= upcoming_req.op;
          s_axis_tdata  <= rpfa_pkg::IN_DATA_W'({upcoming_req.count, upcoming_req.rnd,
                                                 upcoming_req.addr});
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: the stall pattern is picked anew at random intervals.
  rx_pattern_e rx_pattern  = RX_OPEN;
  int unsigned rx_cycles   = 0;
  int unsigned rx_phase    = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_cycles == 0) begin
        rx_pattern = rx_pattern_e'($urandom_range(0, 3));
        rx_cycles  = $urandom_range(8, 80);
      end
      rx_cycles--;
      rx_phase++;
      case (rx_pattern)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: m_axis_tready <= (rx_phase % 4 == 0);
        default:   m_axis_tready <= ($urandom_range(0, 5) != 0);
      endcase
    end
  end

  // Result monitor.
  response_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_responses.size() == 0) begin
        $error("unexpected result transfer: status %0d, page_address 0x%08h",
               m_axis_tuser, m_axis_tdata);
        error_count++;
      end else begin
        want = awaited_responses.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata !== want.page) begin
          $error("page_address: expected 0x%08h, got 0x%08h", want.page, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(50ms);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    logic [rpfa_pkg::ADDR_W-1:0] addr;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Narrow window: rejections, empty list and empty log.
    write_register(rpfa_pkg::CFG_LOW_FRAME, 16);
    write_register(rpfa_pkg::CFG_TOP_FRAME, 1000);
    enqueue(rpfa_pkg::OP_ALLOC, $urandom, 5, $urandom);
    enqueue(rpfa_pkg::OP_DUMP, $urandom, $urandom, 1);
    enqueue(rpfa_pkg::OP_DUMP, $urandom, $urandom, 0);
    enqueue(OP_SPARE, $urandom, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_FREE, 32'(16) << rpfa_pkg::PAGE_BITS, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_FREE, 32'(999) << rpfa_pkg::PAGE_BITS, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_FREE, 32'(1000) << rpfa_pkg::PAGE_BITS, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_FREE, 32'(15) << rpfa_pkg::PAGE_BITS, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_FREE, (32'(100) << rpfa_pkg::PAGE_BITS) | 32'h1, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_FREE, (32'(100) << rpfa_pkg::PAGE_BITS) | 32'h800, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_FREE, 32'hFFFF_F000, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_FREE, 32'h0, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_FREE, 32'(500) << rpfa_pkg::PAGE_BITS, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_FREE, 32'(300) << rpfa_pkg::PAGE_BITS, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_ALLOC, $urandom, 0, $urandom);
    enqueue(rpfa_pkg::OP_ALLOC, $urandom, 32'h7FFF_FFFF, $urandom);
    enqueue(rpfa_pkg::OP_ALLOC, $urandom, 1, $urandom);
    enqueue(rpfa_pkg::OP_DUMP, $urandom, $urandom, 3);
    enqueue(rpfa_pkg::OP_DUMP, $urandom, $urandom, 4);
    enqueue(rpfa_pkg::OP_DUMP, $urandom, $urandom, 65);
    enqueue(rpfa_pkg::OP_DUMP, $urandom, $urandom, 127);
    enqueue(rpfa_pkg::OP_ALLOC, $urandom, 2, $urandom);
    enqueue(rpfa_pkg::OP_ALLOC, $urandom, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_DUMP, $urandom, $urandom, 4);
    drain();

    // Widest window: frames at both ends, a longer list and a longer log.
    write_register(rpfa_pkg::CFG_LOW_FRAME, 0);
    write_register(rpfa_pkg::CFG_TOP_FRAME, 1048576);
    enqueue(rpfa_pkg::OP_FREE, 32'hFFFF_F000, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_FREE, 32'h0, $urandom, $urandom);
    repeat (24) enqueue(rpfa_pkg::OP_FREE,
                        {rpfa_pkg::FRAME_W'($urandom), {rpfa_pkg::PAGE_BITS{1'b0}}},
                        $urandom, $urandom);
    enqueue(rpfa_pkg::OP_FREE, 32'h0000_5000, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_FREE, 32'h0000_5004, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_ALLOC, $urandom, 32'h7FFF_FFFF, $urandom);
    enqueue(rpfa_pkg::OP_ALLOC, $urandom, 26, $urandom);
    repeat (4) enqueue(rpfa_pkg::OP_ALLOC, $urandom, $urandom, $urandom);
    repeat (14) enqueue(rpfa_pkg::OP_ALLOC, $urandom, $urandom_range(0, 3), $urandom);
    enqueue(rpfa_pkg::OP_DUMP, $urandom, $urandom, 64);
    enqueue(rpfa_pkg::OP_DUMP, $urandom, $urandom, 1);
    enqueue(rpfa_pkg::OP_DUMP, $urandom, $urandom, 16);
    drain();

    // Window of one frame at the very top, then an empty window.
    write_register(rpfa_pkg::CFG_LOW_FRAME, 1048575);
    enqueue(rpfa_pkg::OP_FREE, 32'hFFFF_F000, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_FREE, 32'hFFFF_E000, $urandom, $urandom);
    drain();
    write_register(rpfa_pkg::CFG_LOW_FRAME, 0);
    write_register(rpfa_pkg::CFG_TOP_FRAME, 0);
    enqueue(rpfa_pkg::OP_FREE, 32'h0, $urandom, $urandom);
    enqueue(rpfa_pkg::OP_ALLOC, $urandom, $urandom, $urandom);
    drain();

    repeat (2) begin
      lo = $urandom_range(0, 3000);
      hi = lo + $urandom_range(1, 4000);
      write_register(rpfa_pkg::CFG_LOW_FRAME, lo);
      write_register(rpfa_pkg::CFG_TOP_FRAME, hi);
      repeat (70) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          if ($urandom_range(0, 6) == 0) begin
            addr = $urandom;
          end else if ($urandom_range(0, 9) == 0) begin
            addr = {rpfa_pkg::FRAME_W'(($urandom_range(0, 1) == 0) ? lo - 1 : hi),
                    {rpfa_pkg::PAGE_BITS{1'b0}}};
          end else begin
            addr = {rpfa_pkg::FRAME_W'($urandom_range(lo, hi - 1)),
                    {rpfa_pkg::PAGE_BITS{1'b0}}};
          end
          enqueue(rpfa_pkg::OP_FREE, addr, $urandom, $urandom);
        end else if (pick < 75) begin
          enqueue(rpfa_pkg::OP_ALLOC, $urandom,
                  ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : $urandom, $urandom);
        end else if (pick < 95) begin
          enqueue(rpfa_pkg::OP_DUMP, $urandom, $urandom,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64));
        end else begin
          enqueue(OP_SPARE, $urandom, $urandom, $urandom);
        end
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (error_count == 0 && awaited_responses.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
design/rpfa_pkg.sv
design/rpfa_ram.sv
design/rpfa_cell.sv
design/rpfa_mod.sv
design/random_page_frame_allocator.sv
tb/sv/random_page_frame_allocator_tb.sv
